/* src/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and tables for the UTF-8 to UTF-16 decoder
// Result kinds, the result record, lead byte decode and per-length constants.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    typedef enum logic [1:0] {
        KIND_UNIT    = 2'd0,
        KIND_ILLEGAL = 2'd1,
        KIND_TRUNC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] code_unit;
        t_kind       kind;
        logic [2:0]  bad_length;
        logic        last;
    } t_result;

    localparam logic [31:0] MAX_POINT     = 32'h0010FFFF;
    localparam logic [31:0] SUPP_BASE     = 32'h00010000;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;
    localparam logic [31:0] SURR_FIRST    = 32'h0000D800;
    localparam logic [31:0] SURR_LAST     = 32'h0000DFFF;
    localparam logic [31:0] BMP_LAST      = 32'h0000FFFF;
    localparam logic [2:0]  CESU_MAX_LEN  = 3'd3;

    // Sequence length from a lead byte; 0 for ASCII, trail bytes, 0xFE, 0xFF
    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'hC0)      len = 3'd0;
        else if (b < 8'hE0) len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else if (b < 8'hFE) len = 3'd6;
        else                len = 3'd0;
        return len;
    endfunction

    // Accumulated lead and trail bits to remove once a sequence is complete
    function automatic logic [31:0] lead_offset(input logic [2:0] len);
        logic [31:0] off;
        case (len)
            3'd2:    off = 32'h00003080;
            3'd3:    off = 32'h000E2080;
            3'd4:    off = 32'h03C82080;
            3'd5:    off = 32'hFA082080;
            3'd6:    off = 32'h82082080;
            default: off = 32'h00000000;
        endcase
        return off;
    endfunction

    // Smallest code point allowed for a length (shortest form check)
    function automatic logic [31:0] min_point(input logic [2:0] len);
        logic [31:0] mp;
        case (len)
            3'd0, 3'd1: mp = 32'h00000000;
            3'd2:       mp = 32'h00000080;
            3'd3:       mp = 32'h00000800;
            3'd4:       mp = 32'h00010000;
            default:    mp = 32'hFFFFFFFF;
        endcase
        return mp;
    endfunction

endpackage

/* src/utf8_to_utf16_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit: UTF-8 / CESU-8 byte stream to UTF-16 units
// One byte per item in; code units or error records out, up to two per item.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_stall, i_data_byte,      | in
//          | i_flush                                   |
//  output  | o_out_valid, i_out_stall, o_code_unit,    | out
//          | o_kind, o_bad_length, o_last              |
//  config  | i_cfg_wr_en, i_cfg_wr_data (cesu8_mode)   | in
//
// An item is decoded in the cycle it is accepted; its results appear in a
// two-entry result buffer on the next cycle. One item per cycle while each item
// gives at most one result and i_out_stall is low; two results (surrogate pair,
// or error then restarted byte) hold off the next item until the second is
// taken. The buffer drain port sets the rate. Reset is synchronous and clears
// the pending sequence, the buffer and cesu8_mode. Output stall back-pressures
// the input only when the buffer cannot be emptied in the same cycle.
module utf8_to_utf16_decoder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_flush,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_code_unit,
    output u8u16_pkg::t_kind      o_kind,
    output logic [2:0]            o_bad_length,
    output logic                  o_last
);
    import u8u16_pkg::*;

    logic        r_cesu;
    logic [31:0] r_acc;
    logic [2:0]  r_exp;
    logic [2:0]  r_rcv;
    t_result     r_slot [2];
    logic [1:0]  r_cnt;

    logic [31:0] n_acc;
    logic [2:0]  n_exp;
    logic [2:0]  n_rcv;

    logic        in_acc;
    logic        out_take;
    logic        ready;

    logic [31:0] trail_acc;
    logic [2:0]  rcv_inc;
    logic [31:0] ch;
    logic [19:0] supp;
    logic        is_trail;
    logic        ok;
    logic        surr;

    logic [2:0]  fr_len;
    logic        fr_has;
    t_result     fr_res;

    t_result     res_a;
    t_result     res_b;
    logic [1:0]  res_n;

    // ---------------- handshakes ----------------
    assign out_take   = o_out_valid && !i_out_stall;
    assign ready      = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign o_in_stall = !ready;
    assign in_acc     = i_in_valid && ready;

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_code_unit  = r_slot[0].code_unit;
    assign o_kind       = r_slot[0].kind;
    assign o_bad_length = r_slot[0].bad_length;
    assign o_last       = r_slot[0].last;

    // ---------------- datapath ----------------
    assign is_trail  = (i_data_byte[7:6] == 2'b10);
    assign trail_acc = {r_acc[25:0], 6'b0} + {24'b0, i_data_byte};
    assign rcv_inc   = r_rcv + 3'd1;
    assign ch        = trail_acc - lead_offset(r_exp);
    assign supp      = 20'(ch - SUPP_BASE);
    assign surr      = (ch >= SURR_FIRST) && (ch <= SURR_LAST);
    assign ok        = (ch <= MAX_POINT) && (ch >= min_point(r_exp)) &&
                       (r_cesu ? (r_exp <= CESU_MAX_LEN) : !surr);

    // Decode of a byte with no sequence pending
    assign fr_len = seq_length(i_data_byte);
    always_comb begin
        fr_res = '0;
        fr_has = 1'b1;
        if (!i_data_byte[7]) begin
            fr_res.code_unit = {8'b0, i_data_byte};
            fr_res.kind      = KIND_UNIT;
        end else if (fr_len == 3'd0) begin
            fr_res.kind       = KIND_ILLEGAL;
            fr_res.bad_length = 3'd1;
        end else begin
            fr_has = 1'b0;
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_exp = r_exp;
        n_rcv = r_rcv;
        res_a = '0;
        res_b = '0;
        res_n = 2'd0;
        if (i_flush) begin
            if (r_exp != 3'd0) begin
                res_a.kind       = KIND_TRUNC;
                res_a.bad_length = r_rcv;
                res_n            = 2'd1;
                n_acc = '0;
                n_exp = '0;
                n_rcv = '0;
            end
        end else if (r_exp == 3'd0) begin
            if (fr_has) begin
                res_a = fr_res;
                res_n = 2'd1;
            end else begin
                n_acc = {24'b0, i_data_byte};
                n_exp = fr_len;
                n_rcv = 3'd1;
            end
        end else if (is_trail) begin
            n_acc = trail_acc;
            n_rcv = rcv_inc;
            if (rcv_inc >= r_exp) begin
                n_acc = '0;
                n_exp = '0;
                n_rcv = '0;
                if (!ok) begin
                    res_a.kind       = KIND_ILLEGAL;
                    res_a.bad_length = r_exp;
                    res_n            = 2'd1;
                end else if (ch <= BMP_LAST) begin
                    res_a.code_unit = ch[15:0];
                    res_n           = 2'd1;
                end else begin
                    // supplementary plane: high surrogate first
                    res_a.code_unit = HIGH_SURR + {6'b0, supp[19:10]};
                    res_b.code_unit = LOW_SURR + {6'b0, supp[9:0]};
                    res_n           = 2'd2;
                end
            end
        end else begin
            // interrupted sequence, then the byte starts over
            res_a.kind       = KIND_ILLEGAL;
            res_a.bad_length = r_rcv;
            n_acc = '0;
            n_exp = '0;
            n_rcv = '0;
            if (fr_has) begin
                res_b = fr_res;
                res_n = 2'd2;
            end else begin
                res_n = 2'd1;
                n_acc = {24'b0, i_data_byte};
                n_exp = fr_len;
                n_rcv = 3'd1;
            end
        end
        res_a.last = (res_n == 2'd1);
        res_b.last = 1'b1;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cesu <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cesu <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_exp <= '0;
            r_rcv <= '0;
        end else if (in_acc) begin
            r_acc <= n_acc;
            r_exp <= n_exp;
            r_rcv <= n_rcv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_acc) begin
            r_cnt <= res_n;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot[0] <= res_a;
            r_slot[1] <= res_b;
        end else if (out_take) begin
            r_slot[0] <= r_slot[1];
        end
    end

    // ---------------- assertions ----------------
    a_load_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take))
        else $error("item accepted while result buffer still holds results");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_pair_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_slot[0].last && r_slot[1].last)
        else $error("last flag misplaced in a result pair");

    a_pending_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != 3'd0) |-> (r_rcv != 3'd0) && (r_rcv < r_exp) && (r_exp != 3'd1))
        else $error("pending sequence counters inconsistent");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp == 3'd0) |-> (r_rcv == 3'd0))
        else $error("received count set with no sequence pending");

endmodule

/* dv/utf8_to_utf16_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit_tb: self-checking bench for the UTF-8 decoder
// Drives byte and flush items with random gaps and output stalls. A scoreboard
// predicts the code units and error records for each accepted item and
// compares every accepted result, in order, with the oldest prediction.
// Covers hand-picked sequences, then mostly well-formed random sequences,
// with truncated, interrupted and noise items, under both decoding modes.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit_tb;
    import u8u16_pkg::*;

    class decode_scoreboard;
        bit          cesu;
        bit [31:0]   acc;
        bit [2:0]    want_len;
        bit [2:0]    got_len;
        t_result     units_due[$];
        int unsigned faults;

        function void add_unit(logic [15:0] cu, t_kind k, logic [2:0] blen);
            t_result r;
            r.code_unit  = cu;
            r.kind       = k;
            r.bad_length = blen;
            r.last       = 1'b0;
            units_due.push_back(r);
        endfunction

        function bit [2:0] lead_len(bit [7:0] b);
            if (b < 8'hC0)      return 3'd0;
            else if (b < 8'hE0) return 3'd2;
            else if (b < 8'hF0) return 3'd3;
            else if (b < 8'hF8) return 3'd4;
            else if (b < 8'hFC) return 3'd5;
            else if (b < 8'hFE) return 3'd6;
            return 3'd0;
        endfunction

        function void drop_seq();
            acc      = '0;
            want_len = '0;
            got_len  = '0;
        endfunction

        function void close_seq();
            bit [31:0] cp;
            bit [31:0] offset;
            bit [31:0] floor_cp;
            bit [2:0]  len;
            bit        good;
            len = want_len;
            case (len)
                3'd2:    offset = 32'h00003080;
                3'd3:    offset = 32'h000E2080;
                3'd4:    offset = 32'h03C82080;
                3'd5:    offset = 32'hFA082080;
                3'd6:    offset = 32'h82082080;
                default: offset = 32'h00000000;
            endcase
            case (len)
                3'd2:    floor_cp = 32'h00000080;
                3'd3:    floor_cp = 32'h00000800;
                3'd4:    floor_cp = SUPP_BASE;
                default: floor_cp = 32'hFFFFFFFF;
            endcase
            cp = acc - offset;
            good = (cp <= MAX_POINT) && (cp >= floor_cp) &&
                   (cesu ? (len <= CESU_MAX_LEN) : !(cp >= SURR_FIRST && cp <= SURR_LAST));
            drop_seq();
            if (!good) begin
                add_unit(16'h0000, KIND_ILLEGAL, len);
            end else if (cp <= BMP_LAST) begin
                add_unit(cp[15:0], KIND_UNIT, 3'd0);
            end else begin
                cp = cp - SUPP_BASE;
                add_unit(HIGH_SURR + {6'd0, cp[19:10]}, KIND_UNIT, 3'd0);
                add_unit(LOW_SURR + {6'd0, cp[9:0]}, KIND_UNIT, 3'd0);
            end
        endfunction

        function void start_byte(bit [7:0] b);
            bit [2:0] len;
            len = lead_len(b);
            if (b < 8'h80) begin
                add_unit({8'h00, b}, KIND_UNIT, 3'd0);
            end else if (len == 3'd0) begin
                // stray trail byte, 0xFE or 0xFF
                add_unit(16'h0000, KIND_ILLEGAL, 3'd1);
            end else begin
                acc      = {24'd0, b};
                want_len = len;
                got_len  = 3'd1;
            end
        endfunction

        // Predict the results of one accepted item
        function void note_item(bit [7:0] b, bit fl);
            int      before_cnt;
            t_result tail;
            before_cnt = units_due.size();
            if (fl) begin
                if (want_len != 0) begin
                    add_unit(16'h0000, KIND_TRUNC, got_len);
                    drop_seq();
                end
            end else if (want_len == 0) begin
                start_byte(b);
            end else if (b >= 8'h80 && b <= 8'hBF) begin
                acc     = (acc << 6) + {24'd0, b};
                got_len = got_len + 3'd1;
                if (got_len >= want_len)
                    close_seq();
            end else begin
                // interrupted sequence: report it, then decode the byte afresh
                add_unit(16'h0000, KIND_ILLEGAL, got_len);
                drop_seq();
                start_byte(b);
            end
            if (units_due.size() > before_cnt) begin
                tail = units_due.pop_back();
                tail.last = 1'b1;
                units_due.push_back(tail);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (units_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: unit %h kind %0d len %0d last %0b",
                             got.code_unit, got.kind, got.bad_length, got.last);
                return;
            end
            want = units_due.pop_front();
            if (got.code_unit !== want.code_unit || got.kind !== want.kind ||
                got.bad_length !== want.bad_length || got.last !== want.last) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch: expected unit %h kind %0d len %0d last %0b, %s",
                             want.code_unit, want.kind, want.bad_length, want.last,
                             $sformatf("got unit %h kind %0d len %0d last %0b",
                                       got.code_unit, got.kind, got.bad_length,
                                       got.last));
            end
        endfunction
    endclass

    localparam logic [8:0] FLUSH_MARK = 9'h100;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_flush       = 1'b0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_code_unit;
    t_kind       o_kind;
    logic [2:0]  o_bad_length;
    logic        o_last;

    decode_scoreboard board = new();
    bit               calm  = 1'b0;
    int unsigned      items_sent;
    t_result          seen;

    utf8_to_utf16_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_flush       (i_flush),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_unit   (o_code_unit),
        .o_kind        (o_kind),
        .o_bad_length  (o_bad_length),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.code_unit  = o_code_unit;
            seen.kind       = o_kind;
            seen.bad_length = o_bad_length;
            seen.last       = o_last;
            board.check_result(seen);
        end
    end

    // Present one item, hold it until taken, then maybe leave a gap
    task automatic send_item(input logic [7:0] b, input logic fl);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_flush     <= fl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(b, fl);
        items_sent++;
        if (!calm && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic run_script(input logic [8:0] script[]);
        foreach (script[k]) begin
            if (script[k] == FLUSH_MARK)
                send_item(8'($urandom), 1'b1);
            else
                send_item(script[k][7:0], 1'b0);
        end
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (board.units_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        board.cesu = mode;
        i_cfg_wr_en <= 1'b0;
    endtask

    // One random sequence: mostly a lead and its trails, sometimes cut short,
    // sometimes a lone noise byte or a flush
    task automatic send_random_seq();
        int unsigned pick;
        int unsigned n;
        int unsigned cut;
        logic [7:0]  lead;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_item(8'($urandom), 1'b0);
        end else if (pick < 8) begin
            send_item(8'($urandom), 1'b1);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      n = 1;
            else if (pick < 50) n = 2;
            else if (pick < 70) n = 3;
            else if (pick < 88) n = 4;
            else if (pick < 94) n = 5;
            else                n = 6;
            case (n)
                1: lead = 8'($urandom_range(8'h00, 8'h7F));
                2: lead = 8'($urandom_range(8'hC0, 8'hDF));
                3: lead = ($urandom_range(0, 99) < 20) ? 8'hED
                                                       : 8'($urandom_range(8'hE0, 8'hEF));
                4: lead = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(8'hF0, 8'hF4))
                                                       : 8'($urandom_range(8'hF5, 8'hF7));
                5: lead = 8'($urandom_range(8'hF8, 8'hFB));
                default: lead = 8'($urandom_range(8'hFC, 8'hFD));
            endcase
            cut = n;
            if (n > 1 && $urandom_range(0, 99) < 12)
                cut = $urandom_range(1, n - 1);
            send_item(lead, 1'b0);
            for (int unsigned k = 1; k < cut; k++)
                send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            if (cut < n && $urandom_range(0, 1) == 1)
                send_item(8'($urandom), 1'b1);
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target) send_random_seq();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ASCII extremes, 2-byte, U+10FFFF as a pair, stray trail, 0xFF,
        // overlong, interrupted, truncated, idle flush, 6-byte form
        run_script('{9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                     9'h080, 9'h0FF, 9'h0C0, 9'h080, 9'h0E2, 9'h041, 9'h0E2, 9'h082,
                     FLUSH_MARK, FLUSH_MARK, 9'h0FC, 9'h080, 9'h080, 9'h080, 9'h080,
                     9'h080});
        wait_quiet();
        write_mode(1'b1);
        // CESU-8: lone surrogate passes, 4-byte form is refused
        run_script('{9'h0ED, 9'h0A0, 9'h080, 9'h0F0, 9'h090, 9'h080, 9'h080});
        random_phase(125);

        wait_quiet();
        write_mode(1'b0);
        calm = 1'b1;
        random_phase(125);
        calm = 1'b0;

        wait_quiet();
        write_mode(1'b1);
        random_phase(125);

        wait_quiet();
        write_mode(1'b0);
        random_phase(125);

        wait_quiet();
        if (board.units_due.size() != 0)
            board.faults++;
        if (board.faults == 0)
            $display("utf8_to_utf16_decoder_unit_tb: done, clean");
        else
            $display("utf8_to_utf16_decoder_unit_tb: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("utf8_to_utf16_decoder_unit_tb: done, errors");
        $finish;
    end

endmodule
